[rtl/core/esr_pkg.sv]
// Shared constants and register codes for the ellipsoid surface residual block.
package esr_pkg;

	localparam int D_W           = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int CFG_IW        = 3;

	typedef enum logic [CFG_IW-1:0] {
		CFG_CENTER_X = 3'd0,
		CFG_CENTER_Y = 3'd1,
		CFG_CENTER_Z = 3'd2,
		CFG_AXIS_A   = 3'd3,
		CFG_AXIS_B   = 3'd4,
		CFG_AXIS_C   = 3'd5
	} cfg_reg_t;

endpackage

[rtl/core/esr_div3.sv]
// Three-lane pipelined restoring divider, one quotient bit per stage.
module esr_div3 #(
	parameter int NW = 49,
	parameter int DW = 32,
	parameter int SW = 99
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [2:0][NW-1:0]    num,
	input  logic [2:0][DW-1:0]    den,
	input  logic [SW-1:0]         side,
	output logic                  out_valid,
	output logic [2:0][NW-1:0]    quo,
	output logic [SW-1:0]         out_side
);

	logic                  vld_s  [NW+1];
	logic [2:0][DW-1:0]    rem_s  [NW+1];
	logic [2:0][NW-1:0]    nq_s   [NW+1];
	logic [2:0][DW-1:0]    den_s  [NW+1];
	logic [SW-1:0]         side_s [NW+1];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = '0;
	assign nq_s[0]   = num;
	assign den_s[0]  = den;
	assign side_s[0] = side;

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [2:0][DW:0]   t;
		logic [2:0][DW:0]   dif;
		logic [2:0]         ge;
		logic [2:0][DW-1:0] rem_n;
		logic [2:0][NW-1:0] nq_n;

		always_comb begin
			for (int l = 0; l < 3; l++) begin
				t[l]     = {rem_s[k][l], nq_s[k][l][NW-1]};
				dif[l]   = t[l] - {1'b0, den_s[k][l]};
				ge[l]    = t[l] >= {1'b0, den_s[k][l]};
				rem_n[l] = ge[l] ? dif[l][DW-1:0] : t[l][DW-1:0];
				nq_n[l]  = {nq_s[k][l][NW-2:0], ge[l]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= rem_n;
				nq_s[k+1]   <= nq_n;
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[NW];
	assign quo       = nq_s[NW];
	assign out_side  = side_s[NW];

endmodule

[rtl/core/esr_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
module esr_sqrt #(
	parameter int RW = 49,
	parameter int SW = 99
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [2*RW-1:0] rad,
	input  logic [SW-1:0]   side,
	output logic            out_valid,
	output logic [RW-1:0]   root,
	output logic [SW-1:0]   out_side
);

	logic            vld_s  [RW+1];
	logic [2*RW-1:0] rad_s  [RW+1];
	logic [RW:0]     rem_s  [RW+1];
	logic [RW-1:0]   root_s [RW+1];
	logic [SW-1:0]   side_s [RW+1];

	assign vld_s[0]  = in_valid;
	assign rad_s[0]  = rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = side;

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic [RW+2:0] t;
		logic [RW+2:0] trial;
		logic [RW+2:0] dif;
		logic          ge;

		always_comb begin
			t     = {rem_s[k], rad_s[k][2*RW-1 -: 2]};
			trial = {1'b0, root_s[k], 2'b01};
			dif   = t - trial;
			ge    = t >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? dif[RW:0] : t[RW:0];
				root_s[k+1] <= {root_s[k][RW-2:0], ge};
				rad_s[k+1]  <= {rad_s[k][2*RW-3:0], 2'b00};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[RW];
	assign root      = root_s[RW];
	assign out_side  = side_s[RW];

endmodule

[rtl/core/ellipsoid_surface_residual.sv]
// Top level of the ellipsoid surface residual block.
// Takes one point per clock and returns the radial residual to an axis-aligned
// ellipsoid set by the center and semi-axis registers. The pipeline is fully
// streamed: a new point enters every cycle unless the result side stalls. The
// depth is set by two bit-per-stage dividers and a bit-per-stage square root
// of 33+FRAC_BITS stages each, plus a difference stage, three stages of
// squaring and summing, and the output register.
// A stall freezes the whole pipeline. Write the registers only while idle.
module ellipsoid_surface_residual #(
	parameter int FRAC_BITS = esr_pkg::FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [esr_pkg::D_W-1:0]   point_x,
	input  logic [esr_pkg::D_W-1:0]   point_y,
	input  logic [esr_pkg::D_W-1:0]   point_z,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [esr_pkg::D_W-1:0]   resid_x,
	output logic [esr_pkg::D_W-1:0]   resid_y,
	output logic [esr_pkg::D_W-1:0]   resid_z,
	output logic                      at_center,
	output logic                      saturated,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [esr_pkg::CFG_IW-1:0] cfg_index,
	input  logic [esr_pkg::D_W-1:0]   cfg_data
);

	localparam int DW   = esr_pkg::D_W;
	localparam int DLW  = DW + 1;
	localparam int W    = DLW + FRAC_BITS;
	localparam int HL   = (W + 1) / 2;
	localparam int HH   = W - HL;
	localparam int SW   = 2 * W;
	localparam int SIDE = 3 * DLW;
	localparam logic [DW-1:0] AXIS_ONE = DW'(1) << FRAC_BITS;
	localparam logic [DW-1:0] R_MAX    = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] R_MIN    = {1'b1, {(DW-1){1'b0}}};

	logic                en;
	logic [2:0][DW-1:0]  center_q;
	logic [2:0][DW-1:0]  axis_q;

	assign cfg_ready = 1'b1;
	assign en        = !out_valid || !out_stall;
	assign in_stall  = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= '0;
			axis_q   <= {3{AXIS_ONE}};
		end else if (cfg_valid) begin
			unique case (esr_pkg::cfg_reg_t'(cfg_index))
				esr_pkg::CFG_CENTER_X: center_q[0] <= cfg_data;
				esr_pkg::CFG_CENTER_Y: center_q[1] <= cfg_data;
				esr_pkg::CFG_CENTER_Z: center_q[2] <= cfg_data;
				esr_pkg::CFG_AXIS_A:   axis_q[0]   <= cfg_data;
				esr_pkg::CFG_AXIS_B:   axis_q[1]   <= cfg_data;
				esr_pkg::CFG_AXIS_C:   axis_q[2]   <= cfg_data;
				default: ;
			endcase
		end
	end

	// difference to the center
	logic [2:0][DW-1:0]  pt;
	logic [2:0][DLW-1:0] d_n;
	logic [2:0][DLW-1:0] d_s1;
	logic                vld_s1;

	assign pt = {point_z, point_y, point_x};

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			d_n[l] = {pt[l][DW-1], pt[l]} - {center_q[l][DW-1], center_q[l]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= d_n;
		end
	end

	// scale by the semi-axes
	logic [2:0][W-1:0]   num1;
	logic [2:0][DW-1:0]  den1;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			num1[l] = {(d_s1[l][DLW-1] ? (~d_s1[l] + DLW'(1)) : d_s1[l]),
				{FRAC_BITS{1'b0}}};
			den1[l] = (axis_q[l] == '0) ? DW'(1) : axis_q[l];
		end
	end

	logic                vld_d1;
	logic [2:0][W-1:0]   u_d1;
	logic [SIDE-1:0]     side_d1;

	esr_div3 #(.NW(W), .DW(DW), .SW(SIDE)) u_div_axis (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s1),
		.num       (num1),
		.den       (den1),
		.side      (d_s1),
		.out_valid (vld_d1),
		.quo       (u_d1),
		.out_side  (side_d1)
	);

	// squares as partial products, then sum
	logic [2:0][2*HL-1:0] pll_s2;
	logic [2:0][2*HH-1:0] phh_s2;
	logic [2:0][W-1:0]    phl_s2;
	logic [SIDE-1:0]      d_s2;
	logic                 vld_s2;
	logic [2:0][SW-1:0]   sq_s3;
	logic [SIDE-1:0]      d_s3;
	logic                 vld_s3;
	logic [SW-1:0]        sum_s4;
	logic [SIDE-1:0]      d_s4;
	logic                 vld_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_d1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				pll_s2[l] <= (2*HL)'(u_d1[l][HL-1:0]) * (2*HL)'(u_d1[l][HL-1:0]);
				phh_s2[l] <= (2*HH)'(u_d1[l][W-1:HL]) * (2*HH)'(u_d1[l][W-1:HL]);
				phl_s2[l] <= W'(u_d1[l][W-1:HL]) * W'(u_d1[l][HL-1:0]);
				sq_s3[l]  <= {phh_s2[l], pll_s2[l]} + (SW'(phl_s2[l]) << (HL + 1));
			end
			d_s2   <= side_d1;
			d_s3   <= d_s2;
			sum_s4 <= sq_s3[0] + sq_s3[1] + sq_s3[2];
			d_s4   <= d_s3;
		end
	end

	logic            vld_r;
	logic [W-1:0]    root_r;
	logic [SIDE-1:0] side_r;

	esr_sqrt #(.RW(W), .SW(SIDE)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s4),
		.rad       (sum_s4),
		.side      (d_s4),
		.out_valid (vld_r),
		.root      (root_r),
		.out_side  (side_r)
	);

	// divide by the norm
	logic [2:0][DLW-1:0] d_r;
	logic [2:0][W-1:0]   num2;
	logic [2:0][W-1:0]   den2;

	assign d_r = side_r;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			num2[l] = {(d_r[l][DLW-1] ? (~d_r[l] + DLW'(1)) : d_r[l]),
				{FRAC_BITS{1'b0}}};
			den2[l] = (root_r == '0) ? W'(1) : root_r;
		end
	end

	logic                vld_d2;
	logic [2:0][W-1:0]   q_d2;
	logic [SIDE-1:0]     side_d2;

	esr_div3 #(.NW(W), .DW(W), .SW(SIDE)) u_div_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_r),
		.num       (num2),
		.den       (den2),
		.side      (d_r),
		.out_valid (vld_d2),
		.quo       (q_d2),
		.out_side  (side_d2)
	);

	// residual and clamp
	logic [2:0][DLW-1:0] d_o;
	logic [2:0][W+1:0]   r_n;
	logic [2:0][DW-1:0]  rc_n;
	logic [2:0]          clip_n;

	assign d_o = side_d2;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			r_n[l] = d_o[l][DLW-1]
				? {{(W+2-DLW){d_o[l][DLW-1]}}, d_o[l]} + {2'b00, q_d2[l]}
				: {{(W+2-DLW){d_o[l][DLW-1]}}, d_o[l]} - {2'b00, q_d2[l]};
			clip_n[l] = !((r_n[l][W+1:DW-1] == '0) || (r_n[l][W+1:DW-1] == '1));
			rc_n[l]   = clip_n[l] ? (r_n[l][W+1] ? R_MIN : R_MAX) : r_n[l][DW-1:0];
		end
	end

	logic               out_vld_q;
	logic [2:0][DW-1:0] resid_q;
	logic               at_center_q;
	logic               sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_d2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			resid_q     <= rc_n;
			at_center_q <= (d_o == '0);
			sat_q       <= |clip_n;
		end
	end

	assign out_valid = out_vld_q;
	assign resid_x   = resid_q[0];
	assign resid_y   = resid_q[1];
	assign resid_z   = resid_q[2];
	assign at_center = at_center_q;
	assign saturated = sat_q;

	a_center_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && at_center |-> !saturated)
		else $error("saturation flagged on a center point");

	a_center_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && at_center |-> resid_x == '0 && resid_y == '0 && resid_z == '0)
		else $error("nonzero residual on a center point");

	a_sat_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> resid_x == R_MAX || resid_x == R_MIN ||
			resid_y == R_MAX || resid_y == R_MIN ||
			resid_z == R_MAX || resid_z == R_MIN)
		else $error("saturation flagged without a clamped component");

endmodule

[tb/esr_checker.sv]
// Checker: tracks register writes, predicts each residual request and compares results.
module esr_checker
	import esr_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [D_W-1:0]    point_x,
	input  logic [D_W-1:0]    point_y,
	input  logic [D_W-1:0]    point_z,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [D_W-1:0]    resid_x,
	input  logic [D_W-1:0]    resid_y,
	input  logic [D_W-1:0]    resid_z,
	input  logic              at_center,
	input  logic              saturated,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [D_W-1:0]    cfg_data,
	output int                errors,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [D_W-1:0] rx;
		logic [D_W-1:0] ry;
		logic [D_W-1:0] rz;
		logic           at_ctr;
		logic           sat;
	} resid_t;

	longint         center_q[3];
	logic [63:0]    axis_q[3];
	resid_t         resid_fifo[$];

	function automatic resid_t predict_residual(logic [D_W-1:0] px, logic [D_W-1:0] py,
			logic [D_W-1:0] pz);
		logic signed [D_W-1:0] p[3];
		longint                d[3];
		logic [63:0]           mag[3];
		logic [63:0]           a, u, n, t;
		logic [127:0]          acc, sq;
		longint                q, r;
		logic [D_W-1:0]        rv[3];
		resid_t                res;
		p[0] = px;
		p[1] = py;
		p[2] = pz;
		for (int i = 0; i < 3; i++) begin
			d[i] = longint'(p[i]) - center_q[i];
			mag[i] = d[i] < 0 ? 64'(-d[i]) : 64'(d[i]);
		end
		res = '0;
		if (mag[0] == 0 && mag[1] == 0 && mag[2] == 0) begin
			res.at_ctr = 1'b1;
			return res;
		end
		acc = '0;
		for (int i = 0; i < 3; i++) begin
			a = axis_q[i] != 0 ? axis_q[i] : 64'd1;
			u = (mag[i] << FRAC_BITS) / a;
			acc += {64'd0, u} * {64'd0, u};
		end
		n = '0;
		for (int b = 63; b >= 0; b--) begin
			t = n | (64'd1 << b);
			sq = {64'd0, t} * {64'd0, t};
			if (sq <= acc)
				n = t;
		end
		if (n == 0)
			n = 64'd1;
		for (int i = 0; i < 3; i++) begin
			q = longint'((mag[i] << FRAC_BITS) / n);
			r = d[i] < 0 ? d[i] + q : d[i] - q;
			if (r > 64'sd2147483647) begin
				r = 64'sd2147483647;
				res.sat = 1'b1;
			end else if (r < -64'sd2147483648) begin
				r = -64'sd2147483648;
				res.sat = 1'b1;
			end
			rv[i] = r[D_W-1:0];
		end
		res.rx = rv[0];
		res.ry = rv[1];
		res.rz = rv[2];
		return res;
	endfunction

	assign pending = resid_fifo.size();

	always @(posedge clk or negedge arst_n) begin
		resid_t exp_r;
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				center_q[i] = 0;
				axis_q[i] = 64'd1 << FRAC_BITS;
			end
			resid_fifo.delete();
			errors = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (resid_fifo.size() == 0) begin
					$error("unexpected result: resid_x %h", resid_x);
					errors++;
				end else begin
					exp_r = resid_fifo.pop_front();
					if (resid_x !== exp_r.rx) begin
						$error("resid_x: expected %h, got %h", exp_r.rx, resid_x);
						errors++;
					end
					if (resid_y !== exp_r.ry) begin
						$error("resid_y: expected %h, got %h", exp_r.ry, resid_y);
						errors++;
					end
					if (resid_z !== exp_r.rz) begin
						$error("resid_z: expected %h, got %h", exp_r.rz, resid_z);
						errors++;
					end
					if (at_center !== exp_r.at_ctr) begin
						$error("at_center: expected %b, got %b", exp_r.at_ctr, at_center);
						errors++;
					end
					if (saturated !== exp_r.sat) begin
						$error("saturated: expected %b, got %b", exp_r.sat, saturated);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall)
				resid_fifo.insert(resid_fifo.size(),
					predict_residual(point_x, point_y, point_z));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_CENTER_X: center_q[0] = longint'($signed(cfg_data));
					CFG_CENTER_Y: center_q[1] = longint'($signed(cfg_data));
					CFG_CENTER_Z: center_q[2] = longint'($signed(cfg_data));
					CFG_AXIS_A:   axis_q[0] = {32'd0, cfg_data};
					CFG_AXIS_B:   axis_q[1] = {32'd0, cfg_data};
					CFG_AXIS_C:   axis_q[2] = {32'd0, cfg_data};
					default: ;
				endcase
			end
		end
	end

endmodule

[tb/tb_top.sv]
// Testbench top: clock, reset, point and register stimulus, stall control and verdict.
module tb_top;
	import esr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int             FRAC_BITS   = FRAC_BITS_DEF;
	localparam int             DRAIN_WAIT  = 3 * (33 + FRAC_BITS) + 16;
	localparam int             STALL_LIMIT = 5000;
	localparam logic [CFG_IW-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IW-1:0] CFG_SPARE_HI = 3'd7;
	localparam logic [D_W-1:0] ONE         = 32'h0001_0000;
	localparam logic [D_W-1:0] MAX_POS     = 32'h7FFF_FFFF;
	localparam logic [D_W-1:0] MAX_NEG     = 32'h8000_0000;

	logic              clk;
	logic              arst_n;
	logic              in_valid, in_stall;
	logic [D_W-1:0]    point_x, point_y, point_z;
	logic              out_valid, out_stall;
	logic [D_W-1:0]    resid_x, resid_y, resid_z;
	logic              at_center, saturated;
	logic              cfg_valid, cfg_ready;
	logic [CFG_IW-1:0] cfg_index;
	logic [D_W-1:0]    cfg_data;
	int                errors, pending;
	int                in_idle_pct, out_idle_pct;
	int                points_sent, settings_used, quiet_cycles;
	logic [D_W-1:0]    ctr[3];
	logic [D_W-1:0]    axes[3];

	ellipsoid_surface_residual #(.FRAC_BITS(FRAC_BITS)) i_dut (.*);

	esr_checker #(.FRAC_BITS(FRAC_BITS)) i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < out_idle_pct);

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", pending);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_point(logic [D_W-1:0] x, logic [D_W-1:0] y, logic [D_W-1:0] z);
		@(negedge clk);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		point_x  <= x;
		point_y  <= y;
		point_z  <= z;
		do @(posedge clk); while (in_stall);
		points_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IW-1:0] idx, logic [D_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_CENTER_X) ctr[0] = data;
		if (idx == CFG_CENTER_Y) ctr[1] = data;
		if (idx == CFG_CENTER_Z) ctr[2] = data;
		if (idx == CFG_AXIS_A) axes[0] = data;
		if (idx == CFG_AXIS_B) axes[1] = data;
		if (idx == CFG_AXIS_C) axes[2] = data;
	endtask

	task automatic set_shape(logic [D_W-1:0] cx, logic [D_W-1:0] cy, logic [D_W-1:0] cz,
			logic [D_W-1:0] a, logic [D_W-1:0] b, logic [D_W-1:0] c);
		drain();
		write_reg(CFG_CENTER_X, cx);
		write_reg(CFG_CENTER_Y, cy);
		write_reg(CFG_CENTER_Z, cz);
		write_reg(CFG_AXIS_A, a);
		write_reg(CFG_AXIS_B, b);
		write_reg(CFG_AXIS_C, c);
		settings_used++;
	endtask

	function automatic logic [D_W-1:0] coord_near(int i);
		logic [D_W-1:0] off;
		case ($urandom_range(5))
			0, 1: return $urandom();
			2:    return ctr[i];
			3: begin
				off = $urandom();
				return ctr[i] + D_W'($signed(off) >>> $urandom_range(31, 8));
			end
			default: begin
				off = axes[i] >> $urandom_range(3);
				return $urandom_range(1) ? ctr[i] + off : ctr[i] - off;
			end
		endcase
	endfunction

	task automatic random_points(int count);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(15) == 0)
				send_point(ctr[0], ctr[1], ctr[2]);
			else
				send_point(coord_near(0), coord_near(1), coord_near(2));
		end
	endtask

	task automatic random_shape();
		set_shape($urandom(), $urandom(), $urandom() >> $urandom_range(31),
			$urandom() >> $urandom_range(31), $urandom() >> $urandom_range(31),
			$urandom() >> $urandom_range(31));
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		point_x = '0;
		point_y = '0;
		point_z = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_CENTER_X;
		cfg_data = '0;
		quiet_cycles = 0;
		points_sent = 0;
		settings_used = 1;
		in_idle_pct = 31;
		out_idle_pct = 55;
		ctr = '{default: '0};
		axes = '{default: ONE};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_point('0, '0, '0);
		send_point(ONE, '0, '0);
		send_point('0, MAX_NEG, '0);
		send_point(MAX_POS, MAX_POS, MAX_POS);
		send_point(MAX_NEG, MAX_NEG, MAX_NEG);
		send_point(MAX_POS, MAX_NEG, 32'd1);
		send_point(32'd1, '0, '0);
		send_point(32'hFFFF_FFFF, 32'd3, 32'h0000_8000);
		drain();
		write_reg(CFG_SPARE_LO, 32'hDEAD_BEEF);
		write_reg(CFG_SPARE_HI, 32'h1234_5678);
		send_point(ONE, ONE, ONE);
		set_shape(MAX_POS, MAX_NEG, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_point(MAX_POS, MAX_NEG, '0);
		send_point(MAX_POS, MAX_NEG, 32'd1);
		send_point(MAX_NEG, MAX_POS, MAX_NEG);
		set_shape(MAX_NEG, MAX_POS, 32'h0003_0000, '0, 32'd1, '0);
		send_point(MAX_POS, MAX_NEG, '0);
		send_point(MAX_NEG, MAX_POS, 32'h0003_0000);
		send_point(MAX_NEG + 32'd1, MAX_POS, 32'h0003_0000);
		set_shape(32'h0001_8000, 32'hFFFF_0000, 32'h0000_4000, 32'h0002_0000,
			32'h0000_8000, 32'h0004_0000);
		send_point(32'h0003_8000, 32'hFFFF_0000, 32'h0000_4000);
		send_point(32'h0001_8000, 32'hFFFF_8000, 32'h0004_4000);
		random_points(260);

		in_idle_pct = 55;
		out_idle_pct = 31;
		set_shape(MAX_POS, MAX_POS, MAX_POS, 32'hFFFF_FFFF, 32'd1, ONE);
		random_points(60);
		set_shape(MAX_NEG, MAX_NEG, MAX_NEG, 32'd1, 32'hFFFF_FFFF, '0);
		random_points(60);
		random_shape();
		random_points(100);
		random_shape();
		random_points(100);

		in_idle_pct = 0;
		out_idle_pct = 0;
		set_shape('0, '0, '0, ONE, ONE, ONE);
		random_points(100);
		random_shape();
		random_points(100);
		random_shape();
		random_points(100);

		drain();
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("Checked %0d points across %0d center/axis settings,", points_sent,
			settings_used);
		$display("with idle and stall mixes on both channels and out-of-range writes.");
		if (errors == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
